// ===== src/life_cellular_automaton_macros.svh =====
// assertion macros used by the top-level file that checks this block
`ifndef LIFE_CELLULAR_AUTOMATON_MACROS_SVH
`define LIFE_CELLULAR_AUTOMATON_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define LCA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after its trigger
`define LCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lca_pkg.sv =====
// ----------------------------------------------------------------------------
// lca_pkg
// Shared constants, command codes and control/status types for the
// life cellular automaton block.
// ----------------------------------------------------------------------------
package lca_pkg;

    // grid storage size
    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 64;
    localparam int COL_AW    = $clog2(GRID_COLS);
    localparam int ROW_AW    = $clog2(GRID_ROWS);

    // sweep step counter covers the rows plus two pipeline steps
    localparam int STEP_W    = $clog2(GRID_ROWS + 2);

    // transaction field widths
    localparam int CMD_W     = 3;
    localparam int FCOL_W    = 6;
    localparam int FROW_W    = 6;

    // configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;
    localparam logic [CFG_W-1:0]     COLS_RESET  = 7'd60;
    localparam logic [CFG_W-1:0]     ROWS_RESET  = 7'd40;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TOGGLE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic              latch;
        logic              sweep_clr;
        logic              sweep_en;
        logic [STEP_W-1:0] step;
        logic              rd_item;
        logic              look;
        logic              load_out;
    } lca_ctrl_t;

    // datapath to controller status
    typedef struct packed {
        logic             adv_go;
        logic [CFG_W-1:0] rows_act;
        logic             out_free;
    } lca_status_t;

endpackage

// ===== src/lca_ifs.sv =====
// ----------------------------------------------------------------------------
// lca_cmd_if / lca_res_if
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface lca_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [lca_pkg::CMD_W-1:0]  command;
    logic [lca_pkg::FCOL_W-1:0] column;
    logic [lca_pkg::FROW_W-1:0] row;

    modport source (output valid, output command, output column, output row, input ready);
    modport sink   (input valid, input command, input column, input row, output ready);
endinterface

interface lca_res_if;
    logic valid;
    logic ready;
    logic cell_alive;
    logic is_running;
    logic accepted;

    modport source (output valid, output cell_alive, output is_running, output accepted,
                    input ready);
    modport sink   (input valid, input cell_alive, input is_running, input accepted,
                    output ready);
endinterface

// ===== src/lca_ram.sv =====
// ----------------------------------------------------------------------------
// lca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/lca_ctrl.sv =====
// ----------------------------------------------------------------------------
// lca_ctrl
// Controller state machine: accepts a command transaction, runs the row
// sweep for an advance, looks up the addressed cell and hands off the result.
// ----------------------------------------------------------------------------
module lca_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  lca_pkg::lca_status_t status,
    output lca_pkg::lca_ctrl_t   ctrl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_LOOK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [lca_pkg::STEP_W-1:0]  step_reg;
    logic [lca_pkg::STEP_W-1:0]  step_next;
    logic                        sweep_last;

    // the sweep ends on the step that writes the last active row
    assign sweep_last = (step_reg == (lca_pkg::STEP_W'(status.rows_act)
                                      + lca_pkg::STEP_W'(1)));

    // next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd_ready      = 1'b0;
        ctrl           = '0;
        ctrl.step      = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctrl.latch = 1'b1;
                    if (status.adv_go)
                    begin
                        ctrl.sweep_clr = 1'b1;
                        step_next      = '0;
                        state_next     = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_SWEEP:
            begin
                ctrl.sweep_en = 1'b1;
                if (sweep_last)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    step_next = step_reg + lca_pkg::STEP_W'(1);
                end
            end
            S_READ:
            begin
                ctrl.rd_item = 1'b1;
                state_next   = S_LOOK;
            end
            S_LOOK:
            begin
                ctrl.look  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== src/lca_dpath.sv =====
// ----------------------------------------------------------------------------
// lca_dpath
// Datapath: configuration registers, run mode, row memory with per-row
// valid bits, three-row window with one lane per column, result register.
// ----------------------------------------------------------------------------
module lca_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lca_pkg::lca_ctrl_t            ctrl,
    output lca_pkg::lca_status_t          status,
    input  logic [lca_pkg::CMD_W-1:0]     command,
    input  logic [lca_pkg::FCOL_W-1:0]    column,
    input  logic [lca_pkg::FROW_W-1:0]    row,
    input  logic                          cfg_we,
    input  logic [lca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lca_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          res_ready,
    output logic                          res_valid,
    output logic                          cell_alive,
    output logic                          is_running,
    output logic                          accepted
);

    // next generation of one row, one lane per column
    function automatic logic [lca_pkg::GRID_COLS-1:0] life_row(
        input logic [lca_pkg::GRID_COLS-1:0] above,
        input logic [lca_pkg::GRID_COLS-1:0] mid,
        input logic [lca_pkg::GRID_COLS-1:0] below,
        input logic [lca_pkg::GRID_COLS-1:0] mask
    );
        logic [lca_pkg::GRID_COLS+1:0] pa;
        logic [lca_pkg::GRID_COLS+1:0] pm;
        logic [lca_pkg::GRID_COLS+1:0] pb;
        logic [3:0]                    n;
        logic                          alive;
        logic [lca_pkg::GRID_COLS-1:0] res;
        pa  = {1'b0, above & mask, 1'b0};
        pm  = {1'b0, mid & mask, 1'b0};
        pb  = {1'b0, below & mask, 1'b0};
        res = '0;
        for (int c = 0; c < lca_pkg::GRID_COLS; c++)
        begin
            n = 4'(pa[c]) + 4'(pa[c+1]) + 4'(pa[c+2])
              + 4'(pm[c]) + 4'(pm[c+2])
              + 4'(pb[c]) + 4'(pb[c+1]) + 4'(pb[c+2]);
            alive  = (n == 4'd3) || ((n == 4'd2) && pm[c+1]);
            // columns outside the active grid keep their value
            res[c] = mask[c] ? alive : mid[c];
        end
        return res;
    endfunction

    logic [lca_pkg::CFG_W-1:0]     cols_cfg_reg;
    logic [lca_pkg::CFG_W-1:0]     rows_cfg_reg;
    logic [lca_pkg::CFG_W-1:0]     cols_act;
    logic [lca_pkg::CFG_W-1:0]     rows_act;
    logic                          run_mode_reg;
    logic [lca_pkg::GRID_COLS-1:0] col_mask;

    logic [lca_pkg::ROW_AW-1:0]    item_row_reg;
    logic [lca_pkg::COL_AW-1:0]    item_col_reg;
    logic                          inside_reg;
    logic                          acc_reg;
    logic                          toggle_go_reg;
    logic                          cell_res_reg;
    logic                          inside_now;
    logic                          acc_now;

    logic [lca_pkg::GRID_ROWS-1:0] row_valid_reg;
    logic                          rvalid_q_reg;
    logic                          ram_we;
    logic [lca_pkg::ROW_AW-1:0]    ram_waddr;
    logic [lca_pkg::GRID_COLS-1:0] ram_wdata;
    logic                          ram_re;
    logic [lca_pkg::ROW_AW-1:0]    ram_raddr;
    logic [lca_pkg::GRID_COLS-1:0] ram_q;
    logic [lca_pkg::GRID_COLS-1:0] q_eff;

    logic [lca_pkg::GRID_COLS-1:0] prev_reg;
    logic [lca_pkg::GRID_COLS-1:0] cur_reg;
    logic [lca_pkg::GRID_COLS-1:0] next_in;
    logic [lca_pkg::GRID_COLS-1:0] gen_row;
    logic [lca_pkg::GRID_COLS-1:0] col_onehot;
    logic                          step_reads;
    logic                          step_has_data;
    logic                          step_writes;

    logic                          res_valid_reg;
    logic                          res_cell_reg;
    logic                          res_run_reg;
    logic                          res_acc_reg;

    // active grid size saturates at the storage size
    assign cols_act = (int'(cols_cfg_reg) > lca_pkg::GRID_COLS)
                      ? lca_pkg::CFG_W'(lca_pkg::GRID_COLS) : cols_cfg_reg;
    assign rows_act = (int'(rows_cfg_reg) > lca_pkg::GRID_ROWS)
                      ? lca_pkg::CFG_W'(lca_pkg::GRID_ROWS) : rows_cfg_reg;

    // active column mask
    always_comb
    begin
        for (int c = 0; c < lca_pkg::GRID_COLS; c++)
        begin
            col_mask[c] = (c < int'(cols_act));
        end
    end

    // address check and acceptance of the incoming transaction
    assign inside_now = (lca_pkg::CFG_W'(column) < cols_act)
                     && (lca_pkg::CFG_W'(row) < rows_act);

    always_comb
    begin
        case (command)
            lca_pkg::CMD_TOGGLE:  acc_now = !run_mode_reg && inside_now;
            lca_pkg::CMD_START:   acc_now = 1'b1;
            lca_pkg::CMD_STOP:    acc_now = 1'b1;
            lca_pkg::CMD_ADVANCE: acc_now = run_mode_reg;
            lca_pkg::CMD_READ:    acc_now = inside_now;
            default:              acc_now = 1'b0;
        endcase
    end

    // status to the controller
    assign status.adv_go   = (command == lca_pkg::CMD_ADVANCE) && run_mode_reg;
    assign status.rows_act = rows_act;
    assign status.out_free = !res_valid_reg || res_ready;

    // configuration writes and mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= lca_pkg::COLS_RESET;
            rows_cfg_reg <= lca_pkg::ROWS_RESET;
            run_mode_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    lca_pkg::CFG_COLUMNS: cols_cfg_reg <= cfg_data;
                    lca_pkg::CFG_ROWS:    rows_cfg_reg <= cfg_data;
                    default:              ;
                endcase
            end
            if (ctrl.latch && (command == lca_pkg::CMD_START))
            begin
                run_mode_reg <= 1'b1;
            end
            else if (ctrl.latch && (command == lca_pkg::CMD_STOP))
            begin
                run_mode_reg <= 1'b0;
            end
        end
    end

    // transaction capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_go_reg <= 1'b0;
        end
        else if (ctrl.latch)
        begin
            toggle_go_reg <= (command == lca_pkg::CMD_TOGGLE) && acc_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            item_row_reg <= lca_pkg::ROW_AW'(row);
            item_col_reg <= lca_pkg::COL_AW'(column);
            inside_reg   <= inside_now;
            acc_reg      <= acc_now;
        end
    end

    // sweep step decode: read row step, write row step-2
    assign step_reads    = ctrl.step < lca_pkg::STEP_W'(rows_act);
    assign step_has_data = (ctrl.step != '0) && (ctrl.step <= lca_pkg::STEP_W'(rows_act));
    assign step_writes   = ctrl.step >= lca_pkg::STEP_W'(2);

    // rows never written read as dead
    assign q_eff   = ram_q & {lca_pkg::GRID_COLS{rvalid_q_reg}};
    assign next_in = step_has_data ? q_eff : '0;
    assign gen_row = life_row(prev_reg, cur_reg, next_in, col_mask);

    always_comb
    begin
        col_onehot = '0;
        col_onehot[item_col_reg] = 1'b1;
    end

    // memory port selection
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        if (ctrl.sweep_en)
        begin
            if (step_reads)
            begin
                ram_re    = 1'b1;
                ram_raddr = ctrl.step[lca_pkg::ROW_AW-1:0];
            end
            if (step_writes)
            begin
                ram_we    = 1'b1;
                ram_waddr = lca_pkg::ROW_AW'(ctrl.step - lca_pkg::STEP_W'(2));
                ram_wdata = gen_row;
            end
        end
        if (ctrl.rd_item)
        begin
            ram_re    = 1'b1;
            ram_raddr = item_row_reg;
        end
        if (ctrl.look && toggle_go_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = item_row_reg;
            ram_wdata = q_eff ^ col_onehot;
        end
    end

    lca_ram #(
        .WIDTH (lca_pkg::GRID_COLS),
        .DEPTH (lca_pkg::GRID_ROWS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // per-row valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_q_reg  <= 1'b0;
        end
        else
        begin
            if (ram_re)
            begin
                rvalid_q_reg <= row_valid_reg[ram_raddr];
            end
            if (ram_we)
            begin
                row_valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // three-row window of the previous generation
    always_ff @(posedge clk)
    begin
        if (ctrl.sweep_clr)
        begin
            prev_reg <= '0;
            cur_reg  <= '0;
        end
        else if (ctrl.sweep_en)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= next_in;
        end
    end

    // addressed cell after the transaction
    always_ff @(posedge clk)
    begin
        if (ctrl.look)
        begin
            cell_res_reg <= inside_reg & (q_eff[item_col_reg] ^ toggle_go_reg);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            res_cell_reg <= cell_res_reg;
            res_run_reg  <= run_mode_reg;
            res_acc_reg  <= acc_reg;
        end
    end

    assign res_valid  = res_valid_reg;
    assign cell_alive = res_cell_reg;
    assign is_running = res_run_reg;
    assign accepted   = res_acc_reg;

endmodule

// ===== src/life_cellular_automaton.sv =====
// ----------------------------------------------------------------------------
// life_cellular_automaton
// B3/S23 cellular automaton over a row-organized cell memory, with edit and
// run modes and one result transaction per command transaction.
// ----------------------------------------------------------------------------
// Each command transaction yields one result transaction. Toggle, start,
// stop, read and refused commands pass through the read, look and done
// states before the next command can be accepted; the result is held in an
// output register, so a waiting result does not stop the next command from
// being accepted, but that command's own result waits in the done state until
// the register is free. An accepted advance first runs the sweep state: the
// grid is swept one row per cycle through the row memory and its single read
// port, with a lane per column computing the new row from a three-row window.
// The grid is dead after reset at once, with no clearing pass, as each row carries a valid bit.
`include "life_cellular_automaton_macros.svh"

module life_cellular_automaton (
    input  logic                          clk,
    input  logic                          rst_n,
    lca_cmd_if.sink                       cmd_chan,
    lca_res_if.source                     res_chan,
    input  logic                          cfg_we,
    input  logic [lca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lca_pkg::CFG_W-1:0]     cfg_data
);

    lca_pkg::lca_ctrl_t   ctrl;
    lca_pkg::lca_status_t status;

    // sequencer
    lca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_chan.valid),
        .cmd_ready (cmd_chan.ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    // grid storage and update lanes
    lca_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .status     (status),
        .command    (cmd_chan.command),
        .column     (cmd_chan.column),
        .row        (cmd_chan.row),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res_ready  (res_chan.ready),
        .res_valid  (res_chan.valid),
        .cell_alive (res_chan.cell_alive),
        .is_running (res_chan.is_running),
        .accepted   (res_chan.accepted)
    );

    // checks
    `LCA_ASSERT_NEXT(a_busy_after_accept, cmd_chan.valid && cmd_chan.ready, !cmd_chan.ready, "command accepted while busy")
    `LCA_ASSERT_SAME(a_load_when_free, ctrl.load_out, !res_chan.valid || res_chan.ready, "result overwritten before transaction")
    `LCA_ASSERT_SAME(a_sweep_no_accept, ctrl.sweep_en, !cmd_chan.ready, "command taken during sweep")
    `LCA_ASSERT_SAME(a_result_from_load, $rose(res_chan.valid), $past(ctrl.load_out), "result without load")

endmodule

// ===== dv/life_cellular_automaton_tb.sv =====
// ----------------------------------------------------------------------------
// life_cellular_automaton_tb
// Self-checking bench for the B3/S23 automaton: directed checks of reset
// state, mode rules, edges and grid size extremes, then random edit/run
// sessions over many grid sizes. Every result transaction is checked in
// order against a cycle-free model of the grid kept in the bench.
// ----------------------------------------------------------------------------
module life_cellular_automaton_tb;

    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 100;

    // codes with no operation behind them
    localparam logic [lca_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [lca_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic cell_alive;
        logic is_running;
        logic accepted;
    } cell_report_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [lca_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lca_pkg::CFG_W-1:0]     cfg_data;

    lca_cmd_if cmd_bus ();
    lca_res_if res_bus ();

    life_cellular_automaton dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_chan  (cmd_bus),
        .res_chan  (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the grid, mode and size registers
    logic [lca_pkg::GRID_COLS-1:0] life_grid [lca_pkg::GRID_ROWS];
    logic                          run_flag;
    logic [lca_pkg::CFG_W-1:0]     cols_reg;
    logic [lca_pkg::CFG_W-1:0]     rows_reg;

    cell_report_t cell_reports_due [$];

    bit steady;
    int fail_count;
    int cycle_count;
    int items_sent;
    int reports_checked;
    int generations;
    int refused_count;
    int size_changes;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, cell_reports_due.size());
            $display("** life_cellular_automaton: FAILED **");
            $finish;
        end
    end

    function automatic int active_cols();
        return (cols_reg > lca_pkg::GRID_COLS) ? lca_pkg::GRID_COLS : int'(cols_reg);
    endfunction

    function automatic int active_rows();
        return (rows_reg > lca_pkg::GRID_ROWS) ? lca_pkg::GRID_ROWS : int'(rows_reg);
    endfunction

    // neighbor lookup, anything off the active grid is dead
    function automatic int alive_at(int c, int r, int ncols, int nrows);
        if (c < 0 || r < 0 || c >= ncols || r >= nrows)
            return 0;
        return int'(life_grid[r][c]);
    endfunction

    // one generation over the active grid, computed from the old grid only
    function automatic void step_generation();
        logic [lca_pkg::GRID_COLS-1:0] next_rows [lca_pkg::GRID_ROWS];
        int ncols;
        int nrows;
        int live;
        ncols = active_cols();
        nrows = active_rows();
        for (int r = 0; r < lca_pkg::GRID_ROWS; r++)
            next_rows[r] = life_grid[r];
        for (int r = 0; r < nrows; r++)
        begin
            for (int c = 0; c < ncols; c++)
            begin
                live = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if (dr != 0 || dc != 0)
                            live += alive_at(c + dc, r + dr, ncols, nrows);
                next_rows[r][c] = (live == 3) || (live == 2 && life_grid[r][c]);
            end
        end
        for (int r = 0; r < lca_pkg::GRID_ROWS; r++)
            life_grid[r] = next_rows[r];
    endfunction

    // apply one command to the shadow state and return the report it gives
    function automatic cell_report_t next_report(
        logic [lca_pkg::CMD_W-1:0]  cmd,
        logic [lca_pkg::FCOL_W-1:0] col,
        logic [lca_pkg::FROW_W-1:0] row
    );
        cell_report_t rep;
        logic in_grid;
        logic acc;
        in_grid = (int'(col) < active_cols()) && (int'(row) < active_rows());
        acc = 1'b0;
        case (cmd)
            lca_pkg::CMD_TOGGLE:
                if (!run_flag && in_grid)
                begin
                    life_grid[row][col] = ~life_grid[row][col];
                    acc = 1'b1;
                end
            lca_pkg::CMD_START:
            begin
                run_flag = 1'b1;
                acc = 1'b1;
            end
            lca_pkg::CMD_STOP:
            begin
                run_flag = 1'b0;
                acc = 1'b1;
            end
            lca_pkg::CMD_ADVANCE:
                if (run_flag)
                begin
                    step_generation();
                    generations++;
                    acc = 1'b1;
                end
            lca_pkg::CMD_READ:
                acc = in_grid;
            default: ;
        endcase
        if (!acc)
            refused_count++;
        rep.cell_alive = in_grid ? life_grid[row][col] : 1'b0;
        rep.is_running = run_flag;
        rep.accepted   = acc;
        return rep;
    endfunction

    // result checker, in order against the oldest expectation
    always @(posedge clk)
    begin : check_results
        cell_report_t due;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (cell_reports_due.size() == 0)
            begin
                $error("result transaction with nothing expected");
                fail_count++;
            end
            else
            begin
                due = cell_reports_due.pop_front();
                reports_checked++;
                if (res_bus.cell_alive !== due.cell_alive)
                begin
                    $error("cell_alive: expected %0b, actual %0b",
                           due.cell_alive, res_bus.cell_alive);
                    fail_count++;
                end
                if (res_bus.is_running !== due.is_running)
                begin
                    $error("is_running: expected %0b, actual %0b",
                           due.is_running, res_bus.is_running);
                    fail_count++;
                end
                if (res_bus.accepted !== due.accepted)
                begin
                    $error("accepted: expected %0b, actual %0b",
                           due.accepted, res_bus.accepted);
                    fail_count++;
                end
            end
        end
    end

    // result side stalls, a fresh draw per transaction
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 19);
            if (stall != 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge clk);
            while (!res_bus.valid)
                @(posedge clk);
        end
    end

    // send one command transaction and record what it should return
    task automatic send_command(input logic [lca_pkg::CMD_W-1:0]  cmd,
                                input logic [lca_pkg::FCOL_W-1:0] col,
                                input logic [lca_pkg::FROW_W-1:0] row);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.command <= cmd;
        cmd_bus.column  <= col;
        cmd_bus.row     <= row;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        cell_reports_due.insert(cell_reports_due.size(), next_report(cmd, col, row));
        items_sent++;
    endtask

    // hold off until every result is back, then let the block settle
    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        while (cell_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write both size registers, only while idle
    task automatic set_grid_size(input logic [lca_pkg::CFG_W-1:0] ncols,
                                 input logic [lca_pkg::CFG_W-1:0] nrows);
        cfg_we    <= 1'b1;
        cfg_index <= lca_pkg::CFG_COLUMNS;
        cfg_data  <= ncols;
        @(posedge clk);
        cols_reg = ncols;
        cfg_index <= lca_pkg::CFG_ROWS;
        cfg_data  <= nrows;
        @(posedge clk);
        rows_reg = nrows;
        cfg_we <= 1'b0;
        size_changes++;
    endtask

    // reset state: reads at the corners of the default grid, idle mode rules
    task automatic test_reset_state();
        send_command(lca_pkg::CMD_READ, 6'd0, 6'd0);
        send_command(lca_pkg::CMD_READ, 6'd59, 6'd39);
        send_command(lca_pkg::CMD_READ, 6'd60, 6'd39);
        send_command(lca_pkg::CMD_READ, 6'd63, 6'd63);
        send_command(lca_pkg::CMD_ADVANCE, 6'd0, 6'd0);
        send_command(lca_pkg::CMD_STOP, 6'd0, 6'd0);
        send_command(CMD_UNUSED_FIRST, 6'd1, 6'd1);
        send_command(CMD_UNUSED_LAST, 6'd63, 6'd63);
        drain_results();
    endtask

    // mode rules and a block formed at the top left corner
    task automatic test_modes_and_corner();
        send_command(lca_pkg::CMD_TOGGLE, 6'd0, 6'd0);
        send_command(lca_pkg::CMD_TOGGLE, 6'd1, 6'd0);
        send_command(lca_pkg::CMD_TOGGLE, 6'd0, 6'd1);
        send_command(lca_pkg::CMD_TOGGLE, 6'd60, 6'd0);
        send_command(lca_pkg::CMD_START, 6'd0, 6'd0);
        send_command(lca_pkg::CMD_START, 6'd0, 6'd0);
        send_command(lca_pkg::CMD_TOGGLE, 6'd5, 6'd5);
        send_command(lca_pkg::CMD_ADVANCE, 6'd1, 6'd1);
        send_command(lca_pkg::CMD_STOP, 6'd0, 6'd0);
        drain_results();
    endtask

    // size extremes: saturation, empty grid, cells kept outside a shrunk grid
    task automatic test_size_extremes();
        set_grid_size(7'd127, 7'd127);
        send_command(lca_pkg::CMD_TOGGLE, 6'd61, 6'd63);
        send_command(lca_pkg::CMD_TOGGLE, 6'd62, 6'd63);
        send_command(lca_pkg::CMD_TOGGLE, 6'd63, 6'd63);
        drain_results();
        set_grid_size(7'd62, 7'd64);
        send_command(lca_pkg::CMD_START, 6'd0, 6'd0);
        send_command(lca_pkg::CMD_ADVANCE, 6'd61, 6'd62);
        drain_results();
        set_grid_size(7'd0, 7'd0);
        send_command(lca_pkg::CMD_READ, 6'd0, 6'd0);
        send_command(lca_pkg::CMD_ADVANCE, 6'd0, 6'd0);
        send_command(lca_pkg::CMD_STOP, 6'd0, 6'd0);
        drain_results();
        set_grid_size(7'd64, 7'd64);
        send_command(lca_pkg::CMD_READ, 6'd63, 6'd63);
        send_command(lca_pkg::CMD_READ, 6'd61, 6'd62);
        drain_results();
    endtask

    function automatic logic [lca_pkg::FCOL_W-1:0] pick_col(bit anywhere);
        if (anywhere || active_cols() == 0)
            return lca_pkg::FCOL_W'($urandom_range(0, lca_pkg::GRID_COLS - 1));
        return lca_pkg::FCOL_W'($urandom_range(0, active_cols() - 1));
    endfunction

    function automatic logic [lca_pkg::FROW_W-1:0] pick_row(bit anywhere);
        if (anywhere || active_rows() == 0)
            return lca_pkg::FROW_W'($urandom_range(0, lca_pkg::GRID_ROWS - 1));
        return lca_pkg::FROW_W'($urandom_range(0, active_rows() - 1));
    endfunction

    // a stray command anywhere, any code
    task automatic send_noise();
        send_command(lca_pkg::CMD_W'($urandom_range(0, 7)), pick_col(1'b1), pick_row(1'b1));
    endtask

    // random sessions: seed a pattern, run some generations, read it back
    task automatic test_random_sessions();
        int start_count;
        int seeds;
        int steps;
        logic [lca_pkg::CFG_W-1:0] ncols;
        logic [lca_pkg::CFG_W-1:0] nrows;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            drain_results();
            case ($urandom_range(0, 9))
                0:
                begin
                    ncols = lca_pkg::CFG_W'($urandom_range(0, 1));
                    nrows = 7'd64;
                end
                1:
                begin
                    ncols = 7'd127;
                    nrows = lca_pkg::CFG_W'($urandom_range(0, 127));
                end
                2:
                begin
                    ncols = lca_pkg::CFG_W'($urandom_range(0, 127));
                    nrows = 7'd1;
                end
                default:
                begin
                    ncols = lca_pkg::CFG_W'($urandom_range(3, 12));
                    nrows = lca_pkg::CFG_W'($urandom_range(3, 12));
                end
            endcase
            set_grid_size(ncols, nrows);
            steady = ($urandom_range(0, 3) == 0);

            // edit phase
            send_command(lca_pkg::CMD_STOP, pick_col(1'b1), pick_row(1'b1));
            seeds = $urandom_range(4, 12);
            repeat (seeds)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_noise();
                else
                    send_command(lca_pkg::CMD_TOGGLE, pick_col(1'b0), pick_row(1'b0));
            end

            // run phase
            send_command(lca_pkg::CMD_START, pick_col(1'b1), pick_row(1'b1));
            steps = $urandom_range(1, 5);
            repeat (steps)
            begin
                send_command(lca_pkg::CMD_ADVANCE, pick_col(1'b0), pick_row(1'b0));
                repeat ($urandom_range(0, 2))
                    send_command(lca_pkg::CMD_READ, pick_col(1'b0), pick_row(1'b0));
                if ($urandom_range(0, 5) == 0)
                    send_noise();
            end
            send_command(lca_pkg::CMD_STOP, pick_col(1'b0), pick_row(1'b0));
            repeat ($urandom_range(1, 3))
                send_command(lca_pkg::CMD_READ, pick_col(1'b0), pick_row(1'b0));
        end
        steady = 1'b0;
        drain_results();
    endtask

    // stimulus
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = lca_pkg::CFG_COLUMNS;
        cfg_data        = '0;
        cmd_bus.valid   = 1'b0;
        cmd_bus.command = lca_pkg::CMD_READ;
        cmd_bus.column  = '0;
        cmd_bus.row     = '0;
        res_bus.ready   = 1'b0;
        for (int r = 0; r < lca_pkg::GRID_ROWS; r++)
            life_grid[r] = '0;
        run_flag        = 1'b0;
        cols_reg        = lca_pkg::COLS_RESET;
        rows_reg        = lca_pkg::ROWS_RESET;
        steady          = 1'b0;
        fail_count      = 0;
        cycle_count     = 0;
        items_sent      = 0;
        reports_checked = 0;
        generations     = 0;
        refused_count   = 0;
        size_changes    = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_modes_and_corner();
        test_size_extremes();
        test_random_sessions();

        if (cell_reports_due.size() != 0)
        begin
            $error("%0d expected results never arrived", cell_reports_due.size());
            fail_count++;
        end
        $display("%0d transactions sent, %0d results checked, %0d generations advanced",
                 items_sent, reports_checked, generations);
        $display("%0d commands refused, %0d grid size settings", refused_count, size_changes);
        if (fail_count == 0)
            $display("** life_cellular_automaton: PASSED **");
        else
            $display("** life_cellular_automaton: FAILED **");
        $finish;
    end

endmodule
